### src/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants for the two-level keyed deque unit: the request
// and response words, command and status codes, and field widths.
// ----------------------------------------------------------------------------
package tdq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 40;
   localparam int AGE_W        = 8;
   localparam int GROUP_W      = 3;
   localparam int PAY_W        = AGE_W + GROUP_W + 1;
   localparam int OCC_W        = 7;
   localparam int CMD_W        = 2;

   // bit 1 of the command selects pop, so the unused code acts as a pop
   localparam int CMD_POP_BIT = 1;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;

   typedef enum logic [2:0] {
      STAT_PUSHED = 3'd0,
      STAT_REJECT = 3'd1,
      STAT_FULL   = 3'd2,
      STAT_POPPED = 3'd3,
      STAT_EMPTY  = 3'd4
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   rec_key;
      logic [AGE_W-1:0]   rec_age;
      logic [GROUP_W-1:0] rec_group;
      logic               rec_female;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [KEY_W-1:0]   out_key;
      logic [AGE_W-1:0]   out_age;
      logic [GROUP_W-1:0] out_group;
      logic               out_female;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

endpackage

### src/two_level_deque_unique_keys_unit.sv
// ----------------------------------------------------------------------------
// two_level_deque_unique_keys_unit
// Bounded double-ended queue of keyed records. Pushes at the back or front
// are refused for a zero key, a key already held, or a full queue; pops take
// the front record. Duplicate keys are found by a serial scan of held slots
// with one comparator on one memory read port.
//
//   channel   ports                     handshake
//   request   start, busy, req_data     word taken when start and not busy
//   response  rsp_valid, rsp_data       one-cycle strobe, always taken
//
// zero-key push and pop of an empty queue: result appears in the cycle after accept
// pop: the front record passes the registered memory read, then ST_POP and the response register
// push: a serial scan of held slots, one held key read and compared per cycle
// reset is synchronous; the stores need no clearing, the block is ready at once
// the receiver cannot stall; busy is high while an item is in work
// ----------------------------------------------------------------------------
module two_level_deque_unique_keys_unit #(
   parameter int CAPACITY = tdq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tdq_pkg::req_type req_data,
   output logic             rsp_valid,
   output tdq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_POP  = 3'b100
   } state_type;

   logic [tdq_pkg::KEY_W-1:0] key_mem [CAPACITY];
   logic [tdq_pkg::PAY_W-1:0] pay_mem [CAPACITY];

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [IDX_W-1:0]          scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tdq_pkg::rsp_type          rsp_ff, rsp_in;
   tdq_pkg::req_type          req_ff, req_in;
   logic [tdq_pkg::KEY_W-1:0] key_rd_ff;
   logic [tdq_pkg::PAY_W-1:0] pay_rd_ff;

   logic                      accept;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          front_next;
   logic [IDX_W-1:0]          front_prev;
   logic [IDX_W-1:0]          scan_next;
   logic [SUM_W-1:0]          back_sum;
   logic [IDX_W-1:0]          back_idx;
   logic                      issue;
   logic                      hit;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign scan_next  = (scan_ptr_ff == LAST_IDX) ? '0 : scan_ptr_ff + 1'b1;
   assign back_sum   = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_idx   = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM)
                                             : IDX_W'(back_sum);
   assign issue      = (issue_cnt_ff < count_ff);
   assign hit        = cmp_vld_ff && (key_rd_ff == req_ff.rec_key);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      scan_ptr_in  = scan_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_vld_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      rd_addr      = front_ff;
      wr_en        = 1'b0;
      wr_addr      = back_idx;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = front_ff;
            if (accept) begin
               req_in = req_data;
               if (req_data.cmd[tdq_pkg::CMD_POP_BIT]) begin
                  if (count_ff == '0) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in           = '0;
                     rsp_in.status    = tdq_pkg::STAT_EMPTY;
                  end else begin
                     state_in = ST_POP;
                  end
               end else if (req_data.rec_key == '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.status    = tdq_pkg::STAT_REJECT;
                  rsp_in.occupancy = tdq_pkg::OCC_W'(count_ff);
               end else begin
                  // first held slot is read this cycle
                  state_in     = ST_SCAN;
                  scan_ptr_in  = front_next;
                  issue_cnt_in = (count_ff != '0) ? CNT_W'(1) : '0;
                  cmp_vld_in   = (count_ff != '0);
               end
            end
         end
         ST_SCAN: begin
            rd_addr = scan_ptr_ff;
            if (hit) begin
               state_in         = ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.status    = tdq_pkg::STAT_REJECT;
               rsp_in.occupancy = tdq_pkg::OCC_W'(count_ff);
            end else if (!issue && !cmp_vld_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (count_ff == CAP_CNT) begin
                  rsp_in.status    = tdq_pkg::STAT_FULL;
                  rsp_in.occupancy = tdq_pkg::OCC_W'(count_ff);
               end else begin
                  wr_en = 1'b1;
                  if (req_ff.cmd == tdq_pkg::CMD_PUSH_FRONT) begin
                     wr_addr  = front_prev;
                     front_in = front_prev;
                  end else begin
                     wr_addr = back_idx;
                  end
                  count_in         = count_ff + 1'b1;
                  rsp_in.status    = tdq_pkg::STAT_PUSHED;
                  rsp_in.occupancy = tdq_pkg::OCC_W'(count_ff + 1'b1);
               end
            end else begin
               cmp_vld_in = issue;
               if (issue) begin
                  scan_ptr_in  = scan_next;
                  issue_cnt_in = issue_cnt_ff + 1'b1;
               end
            end
         end
         ST_POP: begin
            state_in          = ST_IDLE;
            front_in          = front_next;
            count_in          = count_ff - 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.status     = tdq_pkg::STAT_POPPED;
            rsp_in.out_key    = key_rd_ff;
            rsp_in.out_age    = pay_rd_ff[tdq_pkg::AGE_W-1:0];
            rsp_in.out_group  = pay_rd_ff[tdq_pkg::AGE_W +: tdq_pkg::GROUP_W];
            rsp_in.out_female = pay_rd_ff[tdq_pkg::PAY_W-1];
            rsp_in.occupancy  = tdq_pkg::OCC_W'(count_ff - 1'b1);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         scan_ptr_ff  <= '0;
         issue_cnt_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         scan_ptr_ff  <= scan_ptr_in;
         issue_cnt_ff <= issue_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      req_ff <= req_in;
   end

   // key and payload stores, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= req_ff.rec_key;
         pay_mem[wr_addr] <= {req_ff.rec_female, req_ff.rec_group, req_ff.rec_age};
      end
      key_rd_ff <= key_mem[rd_addr];
      pay_rd_ff <= pay_mem[rd_addr];
   end

endmodule

### src/tdq_checker.sv
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks on the keyed deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module tdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tdq_pkg::req_type req_data,
   input logic             rsp_valid,
   input tdq_pkg::rsp_type rsp_data
);

   // a word out needs a word taken or work in hand the cycle before
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("response without an accepted request");

   // only pops carry record data
   a_no_data_unless_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != tdq_pkg::STAT_POPPED) |->
         (rsp_data.out_key == '0 && rsp_data.out_age == '0 &&
          rsp_data.out_group == '0 && rsp_data.out_female == 1'b0))
      else $error("record data on a non-pop response");

   // zero keys are never stored, so a popped key is never zero
   a_popped_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tdq_pkg::STAT_POPPED) |->
         (rsp_data.out_key != '0))
      else $error("zero key popped");

   a_empty_has_no_records: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tdq_pkg::STAT_EMPTY) |->
         (rsp_data.occupancy == '0))
      else $error("empty status with records held");

endmodule

bind two_level_deque_unique_keys_unit tdq_checker u_tdq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
